// ----- rtl/core/tasm_pkg.sv -----
// Shared types and default constants for the three-axis sliding median unit.
// Depends on nothing; imported by tasm_sort_lane and the top level.
package tasm_pkg;

   // Default window length and sample width
   localparam int WINDOW_LEN_DEF  = 7;
   localparam int SAMPLE_BITS_DEF = 16;

   // Top-level sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Control from the sequencer to each sorting lane
   typedef struct packed {
      logic clear;   // empty the sorted list
      logic insert;  // insert the lane's data word this cycle
   } lane_ctrl_type;

endpackage

// ----- rtl/core/tasm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tasm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tasm_sort_lane.sv -----
// Insertion sorter for one axis: takes one window entry a cycle into an
// ascending list and presents the middle entry. Depends on tasm_pkg.
module tasm_sort_lane #(
   parameter int WINDOW_LEN  = 7,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tasm_pkg::lane_ctrl_type       ctrl,
   input  logic signed [SAMPLE_BITS-1:0] ins_data,
   output logic signed [SAMPLE_BITS-1:0] median
);
   import tasm_pkg::*;

   localparam int CW  = $clog2(WINDOW_LEN + 1);
   localparam int MID = WINDOW_LEN / 2;

   logic signed [SAMPLE_BITS-1:0] sort_ff [WINDOW_LEN];
   logic signed [SAMPLE_BITS-1:0] sort_in [WINDOW_LEN];
   logic [CW-1:0]                 cnt_ff;
   logic [WINDOW_LEN-1:0]         le;

   // Mark filled entries not above the new word; sorted, so a prefix
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         le[i] = (CW'(i) < cnt_ff) && (sort_ff[i] <= ins_data);
      end
   end

   // Keep the prefix, drop the new word in after it, shift the rest up
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (le[i]) begin
            sort_in[i] = sort_ff[i];
         end else if (i == 0) begin
            sort_in[i] = ins_data;
         end else if (le[i-1]) begin
            sort_in[i] = ins_data;
         end else begin
            sort_in[i] = sort_ff[i-1];
         end
      end
   end

   // Hold the sorted list
   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            sort_ff[i] <= sort_in[i];
         end
      end
   end

   // Track the fill count
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         cnt_ff <= '0;
      end else if (ctrl.insert) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   assign median = sort_ff[MID];

endmodule

// ----- rtl/core/three_axis_sliding_median_unit.sv -----
// Top level of the three-axis sliding median unit.
// Depends on tasm_pkg, tasm_ram and tasm_sort_lane.
//
// Each accepted beat writes one x/y/z sample into a shared circular window
// of WINDOW_LEN slots and returns one beat with the median of each axis
// window (sorted position WINDOW_LEN/2; the upper middle for even lengths).
// Windows start at zero after reset, so early results include those zeros.
// A new beat is not accepted until the previous one has loaded its result:
// the window lives in a single RAM with one read port, so the window is
// streamed out one slot a cycle into three insertion sorters. After the
// beat is accepted, the scan runs, the registered read of the last slot
// is sorted, the sequencer sees the read pipe empty, and the result
// register loads once the result channel is free. A new beat is accepted
// while a finished result waits on the result channel.
module three_axis_sliding_median_unit #(
   parameter int WINDOW_LEN  = tasm_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = tasm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_z
);
   import tasm_pkg::*;

   localparam int AW = $clog2(WINDOW_LEN);
   localparam int CW = $clog2(WINDOW_LEN + 1);
   localparam int RW = 3 * SAMPLE_BITS;

   state_type            state_ff, state_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_valid_ff;
   logic [WINDOW_LEN-1:0] valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] med_x_ff, med_y_ff, med_z_ff;

   logic                 req_beat;
   logic                 rd_issue;
   logic                 rsp_load;
   logic [AW-1:0]        rd_addr;
   logic [RW-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] ins_x, ins_y, ins_z;
   logic signed [SAMPLE_BITS-1:0] lane_x, lane_y, lane_z;
   lane_ctrl_type        lane_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign rd_issue  = (state_ff == ST_SCAN) && (scan_ff < CW'(WINDOW_LEN));
   assign rd_addr   = scan_ff[AW-1:0];
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Window store: one slot holds all three axes
   tasm_ram #(
      .WIDTH (RW),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_beat),
      .wr_addr (slot_ff),
      .wr_data ({req_accel_z, req_accel_y, req_accel_x}),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Slots never written since reset read as zero
   assign ins_x = rd_valid_ff ? rd_data[SAMPLE_BITS-1:0]               : '0;
   assign ins_y = rd_valid_ff ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]   : '0;
   assign ins_z = rd_valid_ff ? rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS] : '0;

   assign lane_ctrl.clear  = req_beat;
   assign lane_ctrl.insert = rd_pend_ff;

   tasm_sort_lane #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .ins_data (ins_x),
      .median   (lane_x)
   );

   tasm_sort_lane #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .ins_data (ins_y),
      .median   (lane_y)
   );

   tasm_sort_lane #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_z (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .ins_data (ins_z),
      .median   (lane_z)
   );

   // Sequence: write on accept, stream the window out, then load the result
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_issue;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               slot_in  = (slot_ff == AW'(WINDOW_LEN - 1)) ? '0 : slot_ff + AW'(1);
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               scan_in = scan_ff + CW'(1);
            end else if (!rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Mark slots written since reset; pipe the mark alongside the read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         if (rd_issue) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Hold the result beat
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         med_x_ff <= lane_x;
         med_y_ff <= lane_y;
         med_z_ff <= lane_z;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_median_x = med_x_ff;
   assign rsp_median_y = med_y_ff;
   assign rsp_median_z = med_z_ff;

endmodule
